// File: design/text_encoding_sniffer_assert.svh
// Assertion macros for the text encoding sniffer.
`ifndef TEXT_ENCODING_SNIFFER_ASSERT_SVH
`define TEXT_ENCODING_SNIFFER_ASSERT_SVH

// cond must never hold while out of reset
`define TES_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// ante implies cons in the same cycle
`define TES_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: design/tes_pkg.sv
// Shared types, constants and classifiers of the text encoding sniffer.
`timescale 1ns / 1ps

package tes_pkg;

   localparam int SAMPLE_SLOTS_DEF = 16;
   localparam int LIMIT_W = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam int QUEUE_DEPTH = 4;
   localparam int RECS = 4;

   localparam logic [7:0] B_00 = 8'h00;
   localparam logic [7:0] B_40 = 8'h40;
   localparam logic [7:0] B_7E = 8'h7e;
   localparam logic [7:0] B_7F = 8'h7f;
   localparam logic [7:0] B_80 = 8'h80;
   localparam logic [7:0] B_81 = 8'h81;
   localparam logic [7:0] B_9F = 8'h9f;
   localparam logic [7:0] B_BB = 8'hbb;
   localparam logic [7:0] B_BF = 8'hbf;
   localparam logic [7:0] B_C2 = 8'hc2;
   localparam logic [7:0] B_DF = 8'hdf;
   localparam logic [7:0] B_E0 = 8'he0;
   localparam logic [7:0] B_EF = 8'hef;
   localparam logic [7:0] B_F0 = 8'hf0;
   localparam logic [7:0] B_F4 = 8'hf4;
   localparam logic [7:0] B_FC = 8'hfc;
   localparam logic [7:0] B_FE = 8'hfe;
   localparam logic [7:0] B_FF = 8'hff;

   localparam logic [2:0] MLEN_NONE = 3'd0;
   localparam logic [2:0] MLEN_U16 = 3'd2;
   localparam logic [2:0] MLEN_UTF8 = 3'd3;
   localparam logic [2:0] MLEN_U32 = 3'd4;

   typedef enum logic [2:0] {
      ENC_UNKNOWN = 3'd0,
      ENC_ASCII = 3'd1,
      ENC_SJIS = 3'd2,
      ENC_UTF8 = 3'd3,
      ENC_U16BE = 3'd4,
      ENC_U16LE = 3'd5,
      ENC_U32BE = 3'd6,
      ENC_U32LE = 3'd7
   } enc_type;

   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_SJIS = 2'd2,
      CLS_UTF8 = 2'd3
   } cls_type;

   typedef struct packed {
      logic ascii;
      cls_type cls;
      logic [1:0] skip;
   } rec_type;

   typedef struct packed {
      rec_type [RECS-1:0] recs;
      logic [RECS-1:0] use_mask;
      logic last;
      logic empty;
      enc_type mark;
   } entry_type;

   function automatic logic in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic is_cont(logic [7:0] v);
      return in_rng(v, B_80, B_BF);
   endfunction

   // classify the character starting at the top byte of w
   function automatic rec_type classify(logic [31:0] w);
      logic [7:0] b0, b1, b2, b3;
      rec_type r;
      b0 = w[31:24];
      b1 = w[23:16];
      b2 = w[15:8];
      b3 = w[7:0];
      r.ascii = (b0 < B_7F);
      if (in_rng(b0, B_C2, B_DF) && is_cont(b1)) begin
         r.cls = CLS_UTF8;
         r.skip = 2'd1;
      end else if (in_rng(b0, B_E0, B_EF) && is_cont(b1) && is_cont(b2)) begin
         r.cls = CLS_UTF8;
         r.skip = 2'd2;
      end else if (in_rng(b0, B_F0, B_F4) && is_cont(b1) && is_cont(b2) && is_cont(b3)) begin
         r.cls = CLS_UTF8;
         r.skip = 2'd3;
      end else if ((in_rng(b0, B_81, B_9F) || in_rng(b0, B_E0, B_EF)) &&
                   (in_rng(b1, B_40, B_7E) || in_rng(b1, B_80, B_FC))) begin
         r.cls = CLS_SJIS;
         r.skip = 2'd1;
      end else begin
         r.cls = CLS_UNKNOWN;
         r.skip = 2'd0;
      end
      return r;
   endfunction

   // byte-order mark test on the first four bytes, oldest on top
   function automatic enc_type mark_of(logic [31:0] w);
      enc_type m;
      if (w[31:24] == B_EF && w[23:16] == B_BB && w[15:8] == B_BF) begin
         m = ENC_UTF8;
      end else if (w[31:24] == B_FF && w[23:16] == B_FE) begin
         m = ENC_U16LE;
      end else if (w[31:24] == B_FE && w[23:16] == B_FF) begin
         m = ENC_U16BE;
      end else if (w[31:24] == B_00 && w[23:16] == B_00 && w[15:8] == B_FE &&
                   w[7:0] == B_FF) begin
         m = ENC_U32BE;
      end else begin
         m = ENC_UNKNOWN;
      end
      return m;
   endfunction

endpackage

// File: design/text_encoding_sniffer.sv
// Top level of the text encoding sniffer.
`timescale 1ns / 1ps

// Takes one stream byte per cycle and reports the stream's encoding (byte-order
// mark, or a greedy UTF-8 / Shift-JIS scan of up to sample_limit non-ASCII
// characters) as one result transfer for the item flagged is_last. The front
// end classifies every window position as bytes arrive and the back end folds
// those classes into the verdict; a four-entry queue sits between them. A byte
// is taken every cycle while the queue has room. The result is registered
// in the back end when the last item is popped from the queue and held until
// it is taken. An item with byte_valid low and is_last low does nothing.
// csr_wr_data is the sample limit: 0 acts as 1, values above SAMPLE_SLOTS act
// as SAMPLE_SLOTS; write it only between streams.

`include "text_encoding_sniffer_assert.svh"

module text_encoding_sniffer #(
   parameter int SAMPLE_SLOTS = tes_pkg::SAMPLE_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_byte_valid,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_encoding,
   output logic [2:0]                  rsp_mark_length,
   input  logic                        csr_wr_en,
   input  logic [tes_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic [tes_pkg::LIMIT_W-1:0] limit_ff;

   logic q_full, q_push, q_pop, q_empty;
   tes_pkg::entry_type q_entry, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tes_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   tes_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_byte_valid(req_byte_valid),
      .req_is_last   (req_is_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   tes_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   tes_back #(
      .SAMPLE_SLOTS(SAMPLE_SLOTS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .sample_limit   (limit_ff),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_encoding   (rsp_encoding),
      .rsp_mark_length(rsp_mark_length)
   );

   `TES_ASSERT_IMPLY(a_mark4_u32, rsp_valid && rsp_mark_length == tes_pkg::MLEN_U32, rsp_encoding == tes_pkg::ENC_U32BE, "four-byte mark without UTF-32 BE")
   `TES_ASSERT_IMPLY(a_mark2_u16, rsp_valid && rsp_mark_length == tes_pkg::MLEN_U16, rsp_encoding == tes_pkg::ENC_U16BE || rsp_encoding == tes_pkg::ENC_U16LE, "two-byte mark without UTF-16")
   `TES_ASSERT_NEVER(a_no_u32le, rsp_valid && rsp_encoding == tes_pkg::ENC_U32LE, "UTF-32 LE reported")
   `TES_ASSERT_NEVER(a_fifo_push_full, q_push && q_full, "queue push while full")

endmodule

// File: design/tes_front.sv
// Front end: byte window, mark detection and per-position classification.
`timescale 1ns / 1ps

module tes_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_byte_valid,
   input  logic                 req_is_last,
   input  logic                 q_full,
   output logic                 q_push,
   output tes_pkg::entry_type   q_entry
);

   logic [31:0] window_ff, window_in;
   logic [2:0] nseen_ff, nseen_in;
   tes_pkg::enc_type mark_ff, mark_in;

   logic accept, take_byte;
   logic [31:0] padded;
   tes_pkg::enc_type mark_full, mark_all;
   logic [tes_pkg::RECS-1:0] mask;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign take_byte = accept && req_byte_valid;

   always_comb begin
      window_in = take_byte ? {window_ff[23:0], req_data_byte} : window_ff;
      nseen_in = (take_byte && nseen_ff != 3'd4) ? nseen_ff + 3'd1 : nseen_ff;

      mark_full = (take_byte && nseen_ff == 3'd3) ? tes_pkg::mark_of(window_in)
                                                  : tes_pkg::ENC_UNKNOWN;
      mark_in = (mark_ff != tes_pkg::ENC_UNKNOWN) ? mark_ff : mark_full;

      case (nseen_in)
         3'd1: padded = window_in << 24;
         3'd2: padded = window_in << 16;
         3'd3: padded = window_in << 8;
         default: padded = window_in;
      endcase

      mark_all = mark_in;
      if (req_is_last && nseen_in != 3'd0 && nseen_in != 3'd4)
         mark_all = tes_pkg::mark_of(padded);

      for (int k = 0; k < tes_pkg::RECS; k++)
         q_entry.recs[k] = tes_pkg::classify(window_in << (8 * k));

      if (mark_all != tes_pkg::ENC_UNKNOWN) begin
         mask = '0;
      end else if (req_is_last) begin
         case (nseen_in)
            3'd1: mask = 4'b1000;
            3'd2: mask = 4'b1100;
            3'd3: mask = 4'b1110;
            3'd4: mask = take_byte ? 4'b1111 : 4'b1110;
            default: mask = 4'b0000;
         endcase
      end else begin
         mask = (take_byte && nseen_in == 3'd4) ? 4'b0001 : 4'b0000;
      end

      q_entry.use_mask = mask;
      q_entry.last = req_is_last;
      q_entry.empty = (nseen_in == 3'd0);
      q_entry.mark = mark_all;
      q_push = accept && (req_is_last || mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         nseen_ff <= '0;
         mark_ff <= tes_pkg::ENC_UNKNOWN;
      end else if (accept && req_is_last) begin
         window_ff <= '0;
         nseen_ff <= '0;
         mark_ff <= tes_pkg::ENC_UNKNOWN;
      end else if (accept) begin
         window_ff <= window_in;
         nseen_ff <= nseen_in;
         mark_ff <= mark_in;
      end
   end

endmodule

// File: design/tes_fifo.sv
// Short queue of classified transfers between front and back end.
`timescale 1ns / 1ps

module tes_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tes_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output tes_pkg::entry_type   head,
   output logic                 empty
);

   localparam int PTR_W = (tes_pkg::QUEUE_DEPTH > 1) ? $clog2(tes_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tes_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tes_pkg::QUEUE_DEPTH - 1);

   tes_pkg::entry_type slots_ff [tes_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full = (count_ff == CNT_W'(tes_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slots_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) slots_ff[wptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);
         if (pop) rptr_ff <= (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
         if (push && !pop) count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

// File: design/tes_back.sv
// Back end: scan state, verdict and result register.
`timescale 1ns / 1ps

module tes_back #(
   parameter int SAMPLE_SLOTS = tes_pkg::SAMPLE_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tes_pkg::LIMIT_W-1:0] sample_limit,
   input  logic                        q_empty,
   input  tes_pkg::entry_type          q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_encoding,
   output logic [2:0]                  rsp_mark_length
);

   localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1);

   logic [1:0] skip_ff, skip_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   tes_pkg::cls_type first_ff, first_in;
   logic mismatch_ff, mismatch_in;
   logic stopped_ff, stopped_in;

   logic rsp_valid_ff;
   logic [2:0] enc_ff, enc_in;
   logic [2:0] mlen_ff, mlen_in;

   logic [CNT_W-1:0] eff_limit;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop = !q_empty && (!q_head.last || out_free);

   always_comb begin
      if (sample_limit == '0) eff_limit = CNT_W'(1);
      else if (int'(sample_limit) > SAMPLE_SLOTS) eff_limit = CNT_W'(SAMPLE_SLOTS);
      else eff_limit = CNT_W'(sample_limit);
   end

   // up to four positions of one transfer, in stream order
   always_comb begin
      skip_in = skip_ff;
      cnt_in = cnt_ff;
      first_in = first_ff;
      mismatch_in = mismatch_ff;
      stopped_in = stopped_ff;
      for (int k = 0; k < tes_pkg::RECS; k++) begin
         if (!stopped_in && q_head.use_mask[k]) begin
            if (skip_in != 2'd0) begin
               skip_in = skip_in - 2'd1;
            end else if (!q_head.recs[k].ascii) begin
               if (cnt_in == '0) first_in = q_head.recs[k].cls;
               else if (q_head.recs[k].cls != first_in) mismatch_in = 1'b1;
               cnt_in = cnt_in + CNT_W'(1);
               skip_in = q_head.recs[k].skip;
               if (q_head.recs[k].cls == tes_pkg::CLS_UNKNOWN || cnt_in == eff_limit)
                  stopped_in = 1'b1;
            end
         end
      end

      mlen_in = tes_pkg::MLEN_NONE;
      if (q_head.empty) begin
         enc_in = tes_pkg::ENC_UNKNOWN;
      end else if (q_head.mark != tes_pkg::ENC_UNKNOWN) begin
         enc_in = q_head.mark;
         case (q_head.mark)
            tes_pkg::ENC_UTF8: mlen_in = tes_pkg::MLEN_UTF8;
            tes_pkg::ENC_U32BE: mlen_in = tes_pkg::MLEN_U32;
            default: mlen_in = tes_pkg::MLEN_U16;
         endcase
      end else if (cnt_in == '0) begin
         enc_in = tes_pkg::ENC_ASCII;
      end else if (mismatch_in) begin
         enc_in = tes_pkg::ENC_UNKNOWN;
      end else begin
         enc_in = {1'b0, first_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         cnt_ff <= '0;
         first_ff <= tes_pkg::CLS_UNKNOWN;
         mismatch_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (q_pop && q_head.last) begin
         skip_ff <= '0;
         cnt_ff <= '0;
         first_ff <= tes_pkg::CLS_UNKNOWN;
         mismatch_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (q_pop) begin
         skip_ff <= skip_in;
         cnt_ff <= cnt_in;
         first_ff <= first_in;
         mismatch_ff <= mismatch_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop && q_head.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.last) begin
         enc_ff <= enc_in;
         mlen_ff <= mlen_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_encoding = enc_ff;
   assign rsp_mark_length = mlen_ff;

endmodule

// File: tb/sv/text_encoding_sniffer_tb.sv
// Self-checking testbench for the text encoding sniffer: byte streams in, verdicts checked.
`timescale 1ns / 1ps

module text_encoding_sniffer_tb;

   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 170;

   typedef logic [7:0] byte_q_type[$];

   // verdict predictor and store of verdicts still due
   class verdict_board;
      typedef struct {
         tes_pkg::enc_type enc;
         logic [2:0] mlen;
      } verdict_type;

      logic [tes_pkg::LIMIT_W-1:0] limit_reg;
      logic [31:0] window;
      int nbytes;
      int trail_left;
      int sampled;
      tes_pkg::enc_type lead_class;
      tes_pkg::enc_type bom;
      bit disagree;
      bit halted;
      verdict_type verdicts_due[$];
      int errors;

      function new();
         limit_reg = tes_pkg::LIMIT_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         window = '0;
         nbytes = 0;
         trail_left = 0;
         sampled = 0;
         lead_class = tes_pkg::ENC_UNKNOWN;
         bom = tes_pkg::ENC_UNKNOWN;
         disagree = 0;
         halted = 0;
      endfunction

      function void set_limit(logic [tes_pkg::LIMIT_W-1:0] v);
         limit_reg = v;
      endfunction

      function int cap();
         int c;
         c = limit_reg;
         if (c == 0) c = 1;
         if (c > tes_pkg::SAMPLE_SLOTS_DEF) c = tes_pkg::SAMPLE_SLOTS_DEF;
         return c;
      endfunction

      function bit span(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
         return (v >= lo) && (v <= hi);
      endfunction

      function void find_bom(logic [31:0] w);
         if (w[31:8] == 24'hefbbbf) bom = tes_pkg::ENC_UTF8;
         else if (w[31:16] == 16'hfffe) bom = tes_pkg::ENC_U16LE;
         else if (w[31:16] == 16'hfeff) bom = tes_pkg::ENC_U16BE;
         else if (w == 32'h0000feff) bom = tes_pkg::ENC_U32BE;
         if (bom != tes_pkg::ENC_UNKNOWN) halted = 1;
      endfunction

      // character starting at the top byte of w
      function void scan_position(logic [31:0] w);
         logic [7:0] b0, b1, b2, b3;
         tes_pkg::enc_type cls;
         int len;
         if (halted) return;
         if (trail_left > 0) begin
            trail_left--;
            return;
         end
         b0 = w[31:24];
         b1 = w[23:16];
         b2 = w[15:8];
         b3 = w[7:0];
         if (b0 < 8'h7f) return;
         if (span(b0, 8'hc2, 8'hdf) && span(b1, 8'h80, 8'hbf)) begin
            cls = tes_pkg::ENC_UTF8;
            len = 2;
         end else if (span(b0, 8'he0, 8'hef) && span(b1, 8'h80, 8'hbf) &&
                      span(b2, 8'h80, 8'hbf)) begin
            cls = tes_pkg::ENC_UTF8;
            len = 3;
         end else if (span(b0, 8'hf0, 8'hf4) && span(b1, 8'h80, 8'hbf) &&
                      span(b2, 8'h80, 8'hbf) && span(b3, 8'h80, 8'hbf)) begin
            cls = tes_pkg::ENC_UTF8;
            len = 4;
         end else if ((span(b0, 8'h81, 8'h9f) || span(b0, 8'he0, 8'hef)) &&
                      (span(b1, 8'h40, 8'h7e) || span(b1, 8'h80, 8'hfc))) begin
            cls = tes_pkg::ENC_SJIS;
            len = 2;
         end else begin
            cls = tes_pkg::ENC_UNKNOWN;
            len = 1;
         end
         if (sampled == 0) lead_class = cls;
         else if (cls != lead_class) disagree = 1;
         sampled++;
         trail_left = len - 1;
         if (cls == tes_pkg::ENC_UNKNOWN || sampled >= cap()) halted = 1;
      endfunction

      function void take_item(logic [7:0] d, logic bv, logic last);
         logic [31:0] w;
         int n;
         verdict_type v;
         if (bv) begin
            window = {window[23:0], d};
            if (nbytes < 4) begin
               nbytes++;
               if (nbytes == 4) begin
                  find_bom(window);
                  scan_position(window);
               end
            end else begin
               scan_position(window);
            end
         end
         if (!last) return;
         if (nbytes == 0) begin
            v.enc = tes_pkg::ENC_UNKNOWN;
            v.mlen = tes_pkg::MLEN_NONE;
         end else begin
            if (nbytes < 4) begin
               w = window << (8 * (4 - nbytes));
               find_bom(w);
               n = nbytes;
            end else begin
               w = window << 8;
               n = 3;
            end
            // flush the tail positions, zeros read past the end
            for (int i = 0; i < n; i++) begin
               scan_position(w);
               w = w << 8;
            end
            if (bom != tes_pkg::ENC_UNKNOWN) begin
               v.enc = bom;
               v.mlen = (bom == tes_pkg::ENC_UTF8) ? tes_pkg::MLEN_UTF8 :
                        (bom == tes_pkg::ENC_U32BE) ? tes_pkg::MLEN_U32 : tes_pkg::MLEN_U16;
            end else begin
               v.mlen = tes_pkg::MLEN_NONE;
               if (sampled == 0) v.enc = tes_pkg::ENC_ASCII;
               else if (disagree) v.enc = tes_pkg::ENC_UNKNOWN;
               else v.enc = lead_class;
            end
         end
         verdicts_due.push_back(v);
         restart();
      endfunction

      function void match_verdict(logic [2:0] enc, logic [2:0] mlen);
         verdict_type v;
         if (verdicts_due.size() == 0) begin
            $error("result transfer with no verdict due: encoding %0d mark_length %0d",
                   enc, mlen);
            errors++;
            return;
         end
         v = verdicts_due.pop_front();
         if (enc !== v.enc) begin
            $error("encoding: expected %0d, got %0d", v.enc, enc);
            errors++;
         end
         if (mlen !== v.mlen) begin
            $error("mark_length: expected %0d, got %0d", v.mlen, mlen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic req_byte_valid = 1'b0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_encoding;
   logic [2:0] rsp_mark_length;
   logic csr_wr_en = 1'b0;
   logic [tes_pkg::LIMIT_W-1:0] csr_wr_data = '0;

   verdict_board sb = new();
   int burst_left = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int stall_mode = 0;
   int mode_left = 0;
   logic [31:0] tick = '0;

   text_encoding_sniffer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_encoding(rsp_encoding),
      .rsp_mark_length(rsp_mark_length),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // receiver stall pattern
   always @(posedge clock) begin
      tick <= tick + 1;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= (tick[2:0] < 3'd3);
      endcase
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.take_item(req_data_byte, req_byte_valid, req_is_last);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.match_verdict(rsp_encoding, rsp_mark_length);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic put_item(input logic [7:0] d, input logic bv, input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) :
                      $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_byte_valid <= bv;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_stream(input byte_q_type s, input bit empty_tail);
      if (s.size() == 0) begin
         put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         items_sent++;
         return;
      end
      for (int i = 0; i < s.size(); i++) begin
         if ($urandom_range(0, 15) == 0) put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         put_item(s[i], 1'b1, (i == s.size() - 1) && !empty_tail);
         items_sent++;
      end
      if (empty_tail) begin
         put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [tes_pkg::LIMIT_W-1:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(v);
   endtask

   function automatic byte_q_type make_stream();
      byte_q_type s;
      int wa, wu, wj, wn, nchars, r, flavor, n, keep;
      flavor = $urandom_range(0, 9);
      case (flavor)
         0: begin wa = 10; wu = 0; wj = 0; wn = 0; end
         1, 2: begin wa = 6; wu = 4; wj = 0; wn = 0; end
         3, 4: begin wa = 5; wu = 0; wj = 5; wn = 0; end
         5: begin wa = 4; wu = 3; wj = 3; wn = 0; end
         6: begin wa = 4; wu = 2; wj = 2; wn = 2; end
         7: begin wa = 0; wu = 0; wj = 0; wn = 1; end
         default: begin wa = 5; wu = 3; wj = 2; wn = 1; end
      endcase
      if (flavor >= 8) begin
         case ($urandom_range(0, 4))
            0: s = '{8'hef, 8'hbb, 8'hbf};
            1: s = '{8'hff, 8'hfe};
            2: s = '{8'hfe, 8'hff};
            3: s = '{8'h00, 8'h00, 8'hfe, 8'hff};
            default: s = '{8'hff, 8'hfe, 8'h00, 8'h00};
         endcase
      end
      nchars = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      repeat (nchars) begin
         r = $urandom_range(0, wa + wu + wj + wn - 1);
         if (r < wa) begin
            s.push_back(8'($urandom_range(0, 8'h7e)));
         end else if (r < wa + wu) begin
            n = $urandom_range(2, 4);
            case (n)
               2: s.push_back(8'($urandom_range(8'hc2, 8'hdf)));
               3: s.push_back(8'($urandom_range(8'he0, 8'hef)));
               default: s.push_back(8'($urandom_range(8'hf0, 8'hf4)));
            endcase
            repeat (n - 1) s.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end else if (r < wa + wu + wj) begin
            s.push_back(($urandom_range(0, 2) != 0) ? 8'($urandom_range(8'h81, 8'h9f)) :
                        8'($urandom_range(8'he0, 8'hef)));
            s.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h40, 8'h7e)) :
                        8'($urandom_range(8'h80, 8'hfc)));
         end else begin
            s.push_back(8'($urandom_range(0, 255)));
         end
      end
      // short streams exercise partial marks and the end-of-stream window
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, 3);
         while (s.size() > keep) void'(s.pop_back());
      end
      return s;
   endfunction

   task automatic run_phase(input logic [tes_pkg::LIMIT_W-1:0] lim);
      int phase_end;
      wait_quiet();
      write_limit(lim);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
         send_stream(make_stream(), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 19) == 0) wait_quiet();
      end
   endtask

   initial begin
      byte_q_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      s = {};
      send_stream(s, 0);
      s = '{8'hef, 8'hbb, 8'hbf};
      send_stream(s, 0);
      s = '{8'hff, 8'hfe};
      send_stream(s, 0);
      s = '{8'hfe, 8'hff};
      send_stream(s, 0);
      s = '{8'h00, 8'h00, 8'hfe, 8'hff};
      send_stream(s, 0);
      s = '{8'hc3, 8'ha9, 8'h41};
      send_stream(s, 0);
      s = '{8'h82, 8'ha0};
      send_stream(s, 0);
      s = '{8'h7f};
      send_stream(s, 0);
      s = '{8'hf0, 8'h9f, 8'h98, 8'h80};
      send_stream(s, 1);
      s = '{8'he3, 8'h81, 8'h82};
      send_stream(s, 0);
      s = '{8'hff};
      send_stream(s, 0);

      run_phase(5'd0);
      run_phase(5'd1);
      run_phase(5'd31);
      run_phase(5'd17);
      run_phase(5'd16);
      run_phase(5'd2);
      run_phase(5'($urandom_range(0, 31)));
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
